### rtl/ccfd_pkg.sv
// Shared types, constants and the CRC byte step for the COBS/CRC-32 frame decoder.
`default_nettype none

package ccfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CRC_W    = 32;

    // Decoded bytes held back so the trailing CRC never reaches the output.
    localparam int unsigned CRC_BYTES = 4;

    // Size of the frame store on the far side; the length limit never exceeds it minus one.
    localparam int unsigned FRAME_BUFFER_BYTES = 2048;
    localparam int unsigned CNT_MAX            = (1 << CNT_W) - 1;
    localparam int unsigned FRAME_CAP_INT      =
        (FRAME_BUFFER_BYTES - 1 > CNT_MAX) ? CNT_MAX : FRAME_BUFFER_BYTES - 1;
    localparam logic [CNT_W-1:0] FRAME_CAP     = CNT_W'(FRAME_CAP_INT);
    localparam logic [CNT_W-1:0] MAXW_RESET    = CNT_W'(2047);
    localparam logic [CNT_W-1:0] CRC_BYTES_CNT = CNT_W'(CRC_BYTES);

    localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] CODE_LONG = 8'hFF;
    localparam logic [BYTE_W-1:0] DELIM     = 8'h00;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CRC_ERR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GARBAGE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [CNT_W-1:0]    payload_length;
    } ccfd_result_t;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = {1'b0, c[CRC_W-1:1]} ^ (c[0] ? CRC_POLY : {CRC_W{1'b0}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/ccfd_ifs.sv
// Valid/ready channel interfaces: received bytes, decoder results, limit register writes.
`default_nettype none

interface ccfd_rx_if;
    import ccfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfd_res_if;
    import ccfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  payload_length;
    modport source (output valid, output kind, output data_byte, output payload_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_length,
                    output ready);
endinterface

interface ccfd_cfg_if;
    import ccfd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] max_written_bytes;
    modport source (output valid, output max_written_bytes, input ready);
    modport sink   (input valid, input max_written_bytes, output ready);
endinterface

`default_nettype wire

### rtl/cobs_crc32_frame_decoder.sv
// Top level of the COBS frame decoder with CRC-32 check.
`default_nettype none

// COBS frame decoder with CRC-32 check. Raw link bytes enter on rx_in, one
// beat per byte; 0x00 delimits frames. Code and data bytes are decoded with
// the implied zeros restored (none after a 0xff block, none before the
// delimiter), run through a reflected CRC-32 (poly 0xEDB88320, init all ones,
// no final xor) and delayed four bytes, so the trailing CRC never appears on
// res_out. Each payload byte leaves as a beat of kind 0; each delimiter gives
// one status beat: good frame (with payload_length), CRC error, or empty
// frame. A zero inside a block gives a garbage abort; a nonzero byte once the
// decoded count reaches the limit gives an overflow abort, and that byte then
// opens a new frame. The limit is the smaller of the max_written_bytes
// register (reset 2047) and the frame buffer size minus one; write it on
// cfg_wr only while the decoder is idle. Throughput is one byte per clock
// while the sink does not stall: the whole COBS step and the byte-wide CRC
// update sit between the input register and the result register, which an
// accepted byte passes in turn. A stalled sink holds the result register;
// the input register still takes one more byte, then rx_in.ready drops.
module cobs_crc32_frame_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ccfd_rx_if.sink    rx_in,
    ccfd_cfg_if.sink   cfg_wr,
    ccfd_res_if.source res_out
);
    import ccfd_pkg::*;

    logic [CNT_W-1:0]  max_written_reg;
    logic [CNT_W-1:0]  limit;
    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              out_busy;
    logic              fire;
    ccfd_result_t      res;

    // Limit register: always ready, one write per beat.
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_written_reg <= MAXW_RESET;
        end
        else if (cfg_wr.valid)
        begin
            max_written_reg <= cfg_wr.max_written_bytes;
        end
    end

    // Clamp to the frame buffer size minus one.
    assign limit = (max_written_reg < FRAME_CAP) ? max_written_reg : FRAME_CAP;

    // Advance a byte whenever the result register is free or drains now.
    assign fire = item_valid && !out_busy;

    ccfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_in      (rx_in),
        .take       (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    ccfd_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_byte (item_byte),
        .limit     (limit),
        .res       (res)
    );

    ccfd_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire),
        .res     (res),
        .busy    (out_busy),
        .res_out (res_out)
    );

`ifndef ASSERT_OFF
    a_data_only_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.kind != KIND_PAYLOAD) |-> res_out.data_byte == '0)
        else $error("data_byte set on a status beat");

    a_length_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.kind != KIND_GOOD) |-> res_out.payload_length == '0)
        else $error("payload_length set on a non-good beat");

    a_no_advance_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.ready) |-> !fire)
        else $error("decode advanced over a held result");
`endif

endmodule

`default_nettype wire

### rtl/ccfd_in_stage.sv
// Input register: holds one received byte until the decode step takes it.
`default_nettype none

module ccfd_in_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ccfd_rx_if.sink                     rx_in,
    input  wire logic                   take,
    output logic                        item_valid,
    output logic [ccfd_pkg::BYTE_W-1:0] item_byte
);
    import ccfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign rx_in.ready = !valid_reg || take;
    assign valid_next  = (rx_in.valid && rx_in.ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new beat whenever the slot is free or drains this cycle.
    always_ff @(posedge clk)
    begin
        if (rx_in.valid && rx_in.ready)
        begin
            byte_reg <= rx_in.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

### rtl/ccfd_decode.sv
// COBS decode, CRC-32 update, tail delay and frame status, one byte per cycle on fire.
`default_nettype none

module ccfd_decode (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire logic [ccfd_pkg::BYTE_W-1:0] item_byte,
    input  wire logic [ccfd_pkg::CNT_W-1:0]  limit,
    output ccfd_pkg::ccfd_result_t      res
);
    import ccfd_pkg::*;

    logic [BYTE_W-1:0] block_left_reg;
    logic [BYTE_W-1:0] block_left_next;
    logic [BYTE_W-1:0] last_code_reg;
    logic [BYTE_W-1:0] last_code_next;
    logic [CNT_W-1:0]  written_count_reg;
    logic [CNT_W-1:0]  written_count_next;
    logic [CRC_W-1:0]  running_crc_reg;
    logic [CRC_W-1:0]  running_crc_next;
    logic [BYTE_W-1:0] tail_reg [CRC_BYTES];

    logic              over;
    logic              do_push;
    logic [BYTE_W-1:0] push_byte;

    always_comb
    begin
        block_left_next    = block_left_reg;
        last_code_next     = last_code_reg;
        written_count_next = written_count_reg;
        running_crc_next   = running_crc_reg;
        do_push            = 1'b0;
        push_byte          = DELIM;
        res                = '0;

        over = (written_count_reg >= limit) && (item_byte != DELIM);

        if (over)
        begin
            // Abort, then take this byte as the first code of a new frame.
            res.valid          = 1'b1;
            res.kind           = KIND_OVERFLOW;
            written_count_next = '0;
            running_crc_next   = CRC_INIT;
            last_code_next     = item_byte;
            block_left_next    = item_byte - 8'd1;
        end
        else if (block_left_reg != '0)
        begin
            if (item_byte == DELIM)
            begin
                res.valid          = 1'b1;
                res.kind           = KIND_GARBAGE;
                block_left_next    = '0;
                last_code_next     = CODE_LONG;
                written_count_next = '0;
                running_crc_next   = CRC_INIT;
            end
            else
            begin
                do_push         = 1'b1;
                push_byte       = item_byte;
                block_left_next = block_left_reg - 8'd1;
            end
        end
        else if (item_byte == DELIM)
        begin
            res.valid = 1'b1;
            if (written_count_reg == '0 && last_code_reg == CODE_LONG)
            begin
                res.kind = KIND_EMPTY;
            end
            else if (written_count_reg >= CRC_BYTES_CNT && running_crc_reg == '0)
            begin
                res.kind           = KIND_GOOD;
                res.payload_length = written_count_reg - CRC_BYTES_CNT;
            end
            else
            begin
                res.kind = KIND_CRC_ERR;
            end
            block_left_next    = '0;
            last_code_next     = CODE_LONG;
            written_count_next = '0;
            running_crc_next   = CRC_INIT;
        end
        else
        begin
            // New code byte: the implied zero of a previous short block goes in first.
            do_push         = (last_code_reg != CODE_LONG);
            last_code_next  = item_byte;
            block_left_next = item_byte - 8'd1;
        end

        if (do_push)
        begin
            running_crc_next   = crc32_byte(running_crc_reg, push_byte);
            written_count_next = written_count_reg + CNT_W'(1);
            if (written_count_reg >= CRC_BYTES_CNT)
            begin
                res.valid     = 1'b1;
                res.kind      = KIND_PAYLOAD;
                res.data_byte = tail_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_left_reg    <= '0;
            last_code_reg     <= CODE_LONG;
            written_count_reg <= '0;
            running_crc_reg   <= CRC_INIT;
        end
        else if (fire)
        begin
            block_left_reg    <= block_left_next;
            last_code_reg     <= last_code_next;
            written_count_reg <= written_count_next;
            running_crc_reg   <= running_crc_next;
        end
    end

    // Tail delay: advance only on a decoded byte.
    always_ff @(posedge clk)
    begin
        if (fire && do_push)
        begin
            for (int k = 0; k < CRC_BYTES - 1; k++)
            begin
                tail_reg[k] <= tail_reg[k+1];
            end
            tail_reg[CRC_BYTES-1] <= push_byte;
        end
    end

`ifndef ASSERT_OFF
    a_block_below_code: assert property (@(posedge clk) disable iff (!rst_n)
        block_left_reg == '0 || block_left_reg < last_code_reg)
        else $error("block_left not below its code byte");

    a_restart_after_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.valid && res.kind != KIND_PAYLOAD)
        |=> (written_count_reg == '0 && (running_crc_reg == CRC_INIT)))
        else $error("frame state not restarted after a status beat");

    a_block_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !over && block_left_reg != '0 && item_byte != DELIM)
        |=> block_left_reg == $past(block_left_reg) - 8'd1)
        else $error("block countdown skipped");
`endif

endmodule

`default_nettype wire

### rtl/ccfd_out_stage.sv
// Result register: holds one result beat until the sink takes it.
`default_nettype none

module ccfd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ccfd_pkg::ccfd_result_t res,
    output logic                   busy,
    ccfd_res_if.source             res_out
);
    import ccfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [CNT_W-1:0]  len_reg;

    assign busy = valid_reg && !res_out.ready;

    always_comb
    begin
        valid_next = valid_reg && !res_out.ready;
        if (load)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data_byte;
            len_reg  <= res.payload_length;
        end
    end

    assign res_out.valid          = valid_reg;
    assign res_out.kind           = kind_reg;
    assign res_out.data_byte      = data_reg;
    assign res_out.payload_length = len_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the COBS frame decoder with CRC-32 check.
`timescale 1ns / 1ps

module tb_top;
    import ccfd_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  payload_length;
    } beat_t;

    // Cycles with no beat on any channel before the run is declared hung.
    // The limit stays well above the long receiver hold-off and any sender gap.
    localparam int QUIET_LIMIT = 2000;
    // Settle time after the last expected beat: the decoder's latency plus margin.
    localparam int SETTLE_CYCLES = 6;

    logic clk;
    logic rst_n;

    ccfd_rx_if  rx_if ();
    ccfd_res_if res_if ();
    ccfd_cfg_if cfg_if ();

    cobs_crc32_frame_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_in   (rx_if),
        .cfg_wr  (cfg_if),
        .res_out (res_if)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder shadow state, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [7:0]       dec_left;                // data bytes still owed by the current block
    logic [7:0]       dec_code;                // last code byte, 0xff means no implied zero
    logic [CNT_W-1:0] dec_count;               // decoded bytes in the current frame
    logic [31:0]      dec_crc;                 // running reflected CRC-32
    logic [7:0]       dec_tail [CRC_BYTES];    // holds back the last four decoded bytes
    logic [CNT_W-1:0] limit_reg;               // shadow of max_written_bytes

    beat_t pending_beats [$];                  // expected result beats, oldest first

    int fail_count;
    int items_sent;
    int burst_left;
    bit gaps_on;
    int hold_req;                              // receiver hold-off request, in cycles

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void queue_beat(input logic [KIND_W-1:0] k, input logic [7:0] d,
                                       input logic [CNT_W-1:0] len);
        pending_beats.push_back('{kind: k, data_byte: d, payload_length: len});
    endfunction

    function automatic void frame_restart();
        dec_left  = 8'd0;
        dec_code  = CODE_LONG;
        dec_count = '0;
        dec_crc   = CRC_INIT;
    endfunction

    // Feed one decoded byte through the CRC and the tail delay; once the delay
    // is full, the oldest byte leaves as a payload beat.
    function automatic void absorb_decoded(input logic [7:0] b);
        dec_crc = crc_update(dec_crc, b);
        if (dec_count >= CRC_BYTES_CNT)
            queue_beat(KIND_PAYLOAD, dec_tail[0], '0);
        for (int k = 0; k < CRC_BYTES - 1; k++)
            dec_tail[k] = dec_tail[k + 1];
        dec_tail[CRC_BYTES - 1] = b;
        dec_count = dec_count + 1'b1;
    endfunction

    // Advance the shadow decoder by one raw link byte and queue what it emits.
    function automatic void decode_rx_byte(input logic [7:0] b);
        logic [CNT_W-1:0] lim;
        lim = (limit_reg < FRAME_CAP) ? limit_reg : FRAME_CAP;

        // Overflow: report, reopen, and let the same byte start the next frame.
        if (dec_count >= lim && b != DELIM)
        begin
            queue_beat(KIND_OVERFLOW, 8'd0, '0);
            frame_restart();
        end

        if (dec_left != 8'd0)
        begin
            if (b == DELIM)
            begin
                // zero inside a block: the frame is garbage, the zero is eaten
                queue_beat(KIND_GARBAGE, 8'd0, '0);
                frame_restart();
            end
            else
            begin
                absorb_decoded(b);
                dec_left = dec_left - 8'd1;
            end
        end
        else if (b == DELIM)
        begin
            if (dec_count == '0 && dec_code == CODE_LONG)
                queue_beat(KIND_EMPTY, 8'd0, '0);
            else if (dec_count >= CRC_BYTES_CNT && dec_crc == 32'd0)
                queue_beat(KIND_GOOD, 8'd0, dec_count - CRC_BYTES_CNT);
            else
                queue_beat(KIND_CRC_ERR, 8'd0, '0);
            frame_restart();
        end
        else
        begin
            // code byte: restore the zero implied by the previous short block
            if (dec_code != CODE_LONG)
                absorb_decoded(8'h00);
            dec_code = b;
            dec_left = b - 8'd1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Frame construction: payload, CRC appended LSB first, COBS, delimiter.
    // ------------------------------------------------------------------
    function automatic void cobs_encode(input byte_q_t raw, output byte_q_t enc);
        int i;
        int n;
        enc = {};
        i = 0;
        forever
        begin
            n = 0;
            while (i + n < raw.size() && raw[i + n] != 8'h00 && n < 254)
                n++;
            enc.push_back(8'(n + 1));
            for (int k = 0; k < n; k++)
                enc.push_back(raw[i + k]);
            i += n;
            if (i >= raw.size())
                break;
            // a short block stands for one zero; a full 0xff block stands for none
            if (n < 254)
                i++;
        end
    endfunction

    function automatic void build_frame(input byte_q_t payload, output byte_q_t frame);
        logic [31:0] c;
        byte_q_t     raw;
        c = CRC_INIT;
        raw = payload;
        foreach (payload[i])
            c = crc_update(c, payload[i]);
        raw.push_back(c[7:0]);
        raw.push_back(c[15:8]);
        raw.push_back(c[23:16]);
        raw.push_back(c[31:24]);
        cobs_encode(raw, frame);
        frame.push_back(DELIM);
    endfunction

    // Content styles: 0 uniform, 1 mostly nonzero, 2 zero heavy, 3 never zero.
    function automatic void make_payload(input int n, input int style, output byte_q_t p);
        p = {};
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: p.push_back(8'($urandom_range(0, 255)));
                1: p.push_back(($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
                2: p.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
                default: p.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        decode_rx_byte(b);
        items_sent++;
    endtask

    // Send random-length bursts; with gaps on, valid drops for a random gap before most.
    task automatic send_stream(input byte_q_t bytes_in);
        int gap;
        foreach (bytes_in[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 32);
                gap = 0;
                if (gaps_on && $urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
                if (gap > 0)
                begin
                    rx_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            send_byte(bytes_in[i]);
        end
    endtask

    // Drop valid, drain every expected beat, then let the pipeline settle, since
    // a trailing code byte produces no beat but may still sit in the block.
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_if.valid             <= 1'b1;
        cfg_if.max_written_bytes <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        limit_reg = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lone delimiter, empty payload, short frame, zero inside a block, and a
    // payload holding both byte extremes.
    task automatic test_directed();
        byte_q_t pl;
        byte_q_t fr;
        byte_q_t seq;
        seq = {DELIM};
        pl = {};
        build_frame(pl, fr);
        seq = {seq, fr};
        seq = {seq, 8'h02, 8'h11, DELIM};
        seq = {seq, 8'h03, 8'h05, DELIM, DELIM};
        pl = {8'h00, 8'hff};
        build_frame(pl, fr);
        seq = {seq, fr};
        send_stream(seq);
        wait_idle();
    endtask

    // Limit 5: a one-byte payload fits exactly, two overflow.
    // Then limit zero, where every nonzero byte overflows.
    task automatic test_length_limit();
        byte_q_t pl;
        byte_q_t fr;
        write_limit(CNT_W'(5));
        pl = {8'h5a};
        build_frame(pl, fr);
        send_stream(fr);
        pl = {8'h01, 8'h02};
        build_frame(pl, fr);
        send_stream(fr);
        write_limit('0);
        fr = {8'h01, 8'h02, DELIM, 8'h07, DELIM, DELIM};
        send_stream(fr);
        wait_idle();
    endtask

    // At a mid-size limit: the largest good frame, then one byte more, which overflows.
    task automatic test_long_frames();
        byte_q_t pl;
        byte_q_t fr;
        write_limit(CNT_W'(400));
        make_payload(396, 3, pl);
        build_frame(pl, fr);
        send_stream(fr);
        make_payload(397, 1, pl);
        build_frame(pl, fr);
        send_stream(fr);
        wait_idle();
    endtask

    // Hold the receiver off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        byte_q_t pl;
        byte_q_t fr;
        gaps_on = 1'b0;
        hold_req = 300;
        repeat (3)
        begin
            make_payload(10, 0, pl);
            build_frame(pl, fr);
            send_stream(fr);
        end
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // Mostly well-formed frames with random content; the rest is corrupted,
    // cut short, raw noise or bare delimiters.
    task automatic random_phase(input logic [CNT_W-1:0] lim, input int n_items, input bit gaps);
        byte_q_t     pl;
        byte_q_t     fr;
        int          start;
        int          pick;
        int          len;
        int          pos;
        logic [7:0]  v;
        write_limit(lim);
        gaps_on = gaps;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
            make_payload(len, $urandom_range(0, 3), pl);
            build_frame(pl, fr);
            if (pick < 60)
            begin
                // clean frame
            end
            else if (pick < 72)
            begin
                // flip one bit, keep the byte nonzero so it stays inside the frame
                pos = $urandom_range(0, fr.size() - 2);
                v = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
                if (v != 8'h00)
                    fr[pos] = v;
            end
            else if (pick < 80)
            begin
                pos = $urandom_range(1, fr.size() - 2);
                fr[pos] = 8'h00;
            end
            else if (pick < 88)
            begin
                pos = $urandom_range(1, fr.size() - 3);
                fr = fr[0:pos];
                fr.push_back(DELIM);
            end
            else if (pick < 95)
            begin
                fr = {};
                repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom_range(0, 255)));
            end
            else
                fr = {DELIM};
            send_stream(fr);
        end
        wait_idle();
    endtask

    task automatic test_random();
        random_phase(MAXW_RESET, 200, 1'b1);
        random_phase(CNT_W'(5), 120, 1'b1);
        random_phase(CNT_W'($urandom_range(6, 80)), 150, 1'b0);
        random_phase(CNT_W'($urandom_range(5, 2047)), 200, 1'b1);
        random_phase(MAXW_RESET, 150, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a changing pattern; honor hold-off requests.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int         mode;
        int         mode_left;
        int         hold_cnt;
        logic [7:0] mask;
        logic       nxt;
        res_if.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_cnt = 0;
        mask = 8'hff;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
                mask = 8'($urandom) | 8'h01;
            end
            mode_left--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                nxt = 1'b0;
            end
            else
            begin
                case (mode)
                    0: nxt = 1'b1;
                    1: nxt = ($urandom_range(0, 3) != 0);
                    2:
                    begin
                        nxt = mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default: nxt = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_if.ready <= nxt;
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        beat_t exp_beat;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d, data_byte %0h, payload_length %0d",
                       res_if.kind, res_if.data_byte, res_if.payload_length);
                fail_count++;
            end
            else
            begin
                exp_beat = pending_beats.pop_front();
                if (res_if.kind !== exp_beat.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_beat.kind, res_if.kind);
                    fail_count++;
                end
                if (res_if.data_byte !== exp_beat.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h",
                           exp_beat.data_byte, res_if.data_byte);
                    fail_count++;
                end
                if (res_if.payload_length !== exp_beat.payload_length)
                begin
                    $error("payload_length: expected %0d, got %0d",
                           exp_beat.payload_length, res_if.payload_length);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL cobs_crc32_frame_decoder");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.max_written_bytes = '0;
        fail_count = 0;
        items_sent = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_req = 0;
        quiet_cycles = 0;
        limit_reg = MAXW_RESET;
        for (int k = 0; k < CRC_BYTES; k++)
            dec_tail[k] = 8'h00;
        frame_restart();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_length_limit();
        test_long_frames();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS cobs_crc32_frame_decoder");
        else
            $display("FAIL cobs_crc32_frame_decoder");
        $finish;
    end

endmodule

### files.f
rtl/ccfd_pkg.sv
rtl/ccfd_ifs.sv
rtl/ccfd_in_stage.sv
rtl/ccfd_decode.sv
rtl/ccfd_out_stage.sv
rtl/cobs_crc32_frame_decoder.sv
tb/tb_top.sv
